FILE: src/gso_pkg.sv
// Shared constants and rounding helper for the 3x3 Gram-Schmidt orthonormalizer.
// Depends on nothing; every module of the block imports it.
package gso_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 28;

	// internal working format
	localparam int WORK_FRAC = 30;
	localparam int MAG_W     = 30;          // magnitude of a block-scaled component
	localparam int SC_W      = MAG_W + 1;   // signed block-scaled component
	localparam int E_W       = 32;          // signed unit component, WORK_FRAC fraction bits
	localparam int RES_W     = 33;          // signed residual after one projection
	localparam int PROD_W    = 64;
	localparam int SQ_W      = 64;          // sum of squares, padded to an even width
	localparam int ROOT_W    = 32;
	localparam int REM_W     = 36;

	// round v / 2^WORK_FRAC to nearest, ties away from zero
	function automatic logic signed [PROD_W-1:0] rnd_work(input logic signed [PROD_W-1:0] v);
		logic [PROD_W-1:0] m;
		logic [PROD_W-1:0] r;
		m = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
		r = (m + (PROD_W'(1) << (WORK_FRAC - 1))) >> WORK_FRAC;
		return v[PROD_W-1] ? -$signed(r) : $signed(r);
	endfunction

endpackage

FILE: src/gso_scale.sv
// Block scaler: shifts a three-lane vector as a whole so its largest magnitude
// lies in [2^29, 2^30) and flags an all-zero vector. Uses gso_pkg.
module gso_scale #(
	parameter int IW     = 32,
	parameter int SIDE_W = 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic signed [IW-1:0]             in_v [3],
	input  logic [SIDE_W-1:0]                in_side,
	output logic                             out_valid,
	output logic signed [gso_pkg::SC_W-1:0]  out_v [3],
	output logic                             out_zero,
	output logic [SIDE_W-1:0]                out_side
);
	import gso_pkg::*;

	localparam int PW = $clog2(IW);

	logic              valid_s1, valid_s2, valid_s3;
	logic [IW-1:0]     mag_c [3];
	logic [IW-1:0]     mag_s1 [3];
	logic [IW-1:0]     mag_s2 [3];
	logic [2:0]        neg_s1, neg_s2;
	logic [IW-1:0]     any_s1;
	logic [PW-1:0]     pos_c, pos_s2;
	logic              zero_s2, zero_s3;
	logic [SIDE_W-1:0] side_s1, side_s2, side_s3;
	logic [IW+MAG_W-1:0] ext_c [3];
	logic [MAG_W-1:0]  sh_c [3];
	logic signed [SC_W-1:0] v_c [3];
	logic signed [SC_W-1:0] v_s3 [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = in_v[i][IW-1] ? IW'(-in_v[i]) : IW'(in_v[i]);
		end
	end

	// leading one of the OR of the magnitudes is the leading one of the largest
	always_comb begin
		pos_c = '0;
		for (int b = 0; b < IW; b++) begin
			if (any_s1[b]) begin
				pos_c = PW'(b);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ext_c[i] = {{MAG_W{1'b0}}, mag_s2[i]};
			if (int'(pos_s2) > MAG_W - 1) begin
				sh_c[i] = MAG_W'(ext_c[i] >> (int'(pos_s2) - (MAG_W - 1)));
			end else begin
				sh_c[i] = MAG_W'(ext_c[i] << ((MAG_W - 1) - int'(pos_s2)));
			end
			v_c[i] = neg_s2[i] ? -$signed({1'b0, sh_c[i]}) : $signed({1'b0, sh_c[i]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mag_s1[i] <= mag_c[i];
			neg_s1[i] <= in_v[i][IW-1];
			mag_s2[i] <= mag_s1[i];
			v_s3[i]   <= v_c[i];
		end
		any_s1  <= mag_c[0] | mag_c[1] | mag_c[2];
		side_s1 <= in_side;
		neg_s2  <= neg_s1;
		pos_s2  <= pos_c;
		zero_s2 <= (any_s1 == '0);
		side_s2 <= side_s1;
		zero_s3 <= zero_s2;
		side_s3 <= side_s2;
	end

	assign out_valid = valid_s3;
	assign out_v     = v_s3;
	assign out_zero  = zero_s3;
	assign out_side  = side_s3;

endmodule

FILE: src/gso_proj.sv
// Projection remover: three multiplier lanes form the dot product with a unit
// vector, a merge adds it up, then the lanes subtract the scaled unit vector. Uses gso_pkg.
module gso_proj #(
	parameter int SIDE_W = 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic signed [gso_pkg::SC_W-1:0]   in_x [3],
	input  logic signed [gso_pkg::E_W-1:0]    in_e [3],
	input  logic [SIDE_W-1:0]                 in_side,
	output logic                              out_valid,
	output logic signed [gso_pkg::RES_W-1:0]  out_r [3],
	output logic [SIDE_W-1:0]                 out_side
);
	import gso_pkg::*;

	logic [4:0]               valid_q;
	logic [SIDE_W-1:0]        side_s1, side_s2, side_s3, side_s4, side_s5;
	logic signed [SC_W-1:0]   x_s1 [3], x_s2 [3], x_s3 [3], x_s4 [3];
	logic signed [E_W-1:0]    e_s1 [3], e_s2 [3], e_s3 [3];
	logic signed [PROD_W-1:0] prod_s1 [3];
	logic signed [PROD_W-1:0] d_s2;
	logic signed [E_W-1:0]    s_s3;
	logic signed [PROD_W-1:0] m_s4 [3];
	logic signed [RES_W-1:0]  r_s5 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[3:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			prod_s1[i] <= PROD_W'(in_e[i]) * PROD_W'(in_x[i]);
			x_s1[i] <= in_x[i];
			e_s1[i] <= in_e[i];
			x_s2[i] <= x_s1[i];
			e_s2[i] <= e_s1[i];
			x_s3[i] <= x_s2[i];
			e_s3[i] <= e_s2[i];
			m_s4[i] <= PROD_W'(s_s3) * PROD_W'(e_s3[i]);
			x_s4[i] <= x_s3[i];
			r_s5[i] <= RES_W'(x_s4[i]) - RES_W'(rnd_work(m_s4[i]));
		end
		d_s2    <= prod_s1[0] + prod_s1[1] + prod_s1[2];
		s_s3    <= E_W'(rnd_work(d_s2));
		side_s1 <= in_side;
		side_s2 <= side_s1;
		side_s3 <= side_s2;
		side_s4 <= side_s3;
		side_s5 <= side_s4;
	end

	assign out_valid = valid_q[4];
	assign out_r     = r_s5;
	assign out_side  = side_s5;

endmodule

FILE: src/gso_unit.sv
// Normalizer: sum of squares, a pipelined digit-by-digit square root, and three
// long-division lanes that give each component over the norm. Uses gso_pkg.
module gso_unit #(
	parameter int FRAC_BITS = gso_pkg::FRAC_BITS_DEF,
	parameter int SIDE_W    = 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic signed [gso_pkg::SC_W-1:0]  in_v [3],
	input  logic [SIDE_W-1:0]                in_side,
	output logic                             out_valid,
	output logic signed [gso_pkg::E_W-1:0]   out_e [3],
	output logic signed [FRAC_BITS+1:0]      out_o [3],
	output logic [SIDE_W-1:0]                out_side
);
	import gso_pkg::*;

	localparam int OUT_W = FRAC_BITS + 2;
	localparam int DIV_K = ((FRAC_BITS > WORK_FRAC) ? FRAC_BITS : WORK_FRAC) + 1;
	localparam int Q_W   = DIV_K + 1;
	localparam int RT_N  = ROOT_W;

	// front stage
	logic                valid_s1;
	logic [MAG_W-1:0]    mag_c [3];
	logic [MAG_W-1:0]    mag_s1 [3];
	logic [2:0]          neg_s1;
	logic [2*MAG_W-1:0]  sq_s1 [3];
	logic [SIDE_W-1:0]   side_s1;

	// square root stages
	logic                rt_vld  [0:RT_N];
	logic [SQ_W-1:0]     rt_rad  [0:RT_N];
	logic [REM_W-1:0]    rt_rem  [0:RT_N];
	logic [ROOT_W-1:0]   rt_q    [0:RT_N];
	logic [MAG_W-1:0]    rt_mag  [0:RT_N][3];
	logic [2:0]          rt_neg  [0:RT_N];
	logic [SIDE_W-1:0]   rt_side [0:RT_N];
	logic [REM_W-1:0]    rt_rem_c [0:RT_N-1];
	logic [REM_W-1:0]    rt_try_c [0:RT_N-1];
	logic                rt_ge_c  [0:RT_N-1];

	// division stages
	logic                dv_vld  [0:DIV_K];
	logic [ROOT_W-1:0]   dv_n    [0:DIV_K];
	logic [ROOT_W-1:0]   dv_r    [0:DIV_K][3];
	logic [Q_W-1:0]      dv_q    [0:DIV_K][3];
	logic [2:0]          dv_neg  [0:DIV_K];
	logic [SIDE_W-1:0]   dv_side [0:DIV_K];
	logic [ROOT_W-1:0]   a0_c [3];
	logic                ge0_c [3];
	logic [ROOT_W:0]     r2_c [0:DIV_K-1][3];
	logic                ge_c [0:DIV_K-1][3];

	// output stage
	logic                valid_q;
	logic [Q_W-1:0]      qw_c [3];
	logic [Q_W-1:0]      qo_c [3];
	logic [E_W-1:0]      eu_c [3];
	logic [OUT_W-1:0]    ou_c [3];
	logic signed [E_W-1:0]   e_q [3];
	logic signed [OUT_W-1:0] o_q [3];
	logic [SIDE_W-1:0]   side_q;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag_c[i] = MAG_W'(in_v[i][SC_W-1] ? -in_v[i] : in_v[i]);
		end
	end

	// one root bit per stage: bring down two radicand bits, try (4q+1)
	always_comb begin
		for (int j = 0; j < RT_N; j++) begin
			rt_rem_c[j] = {rt_rem[j][REM_W-3:0], rt_rad[j][SQ_W-1 -: 2]};
			rt_try_c[j] = REM_W'({rt_q[j], 2'b01});
			rt_ge_c[j]  = (rt_rem_c[j] >= rt_try_c[j]);
		end
	end

	// restoring division: integer bit first, then one fraction bit per stage
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a0_c[i]  = (ROOT_W'(rt_mag[RT_N][i]) > rt_q[RT_N]) ? rt_q[RT_N]
			                                                    : ROOT_W'(rt_mag[RT_N][i]);
			ge0_c[i] = (a0_c[i] >= rt_q[RT_N]);
		end
		for (int k = 0; k < DIV_K; k++) begin
			for (int i = 0; i < 3; i++) begin
				r2_c[k][i] = {dv_r[k][i], 1'b0};
				ge_c[k][i] = (r2_c[k][i] >= {1'b0, dv_n[k]});
			end
		end
	end

	// round both precisions from the same quotient digits
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qw_c[i] = (dv_q[DIV_K][i] >> (DIV_K - WORK_FRAC - 1)) + Q_W'(1);
			qo_c[i] = (dv_q[DIV_K][i] >> (DIV_K - FRAC_BITS - 1)) + Q_W'(1);
			eu_c[i] = E_W'(qw_c[i] >> 1);
			ou_c[i] = OUT_W'(qo_c[i] >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_q  <= 1'b0;
			for (int j = 0; j <= RT_N; j++) begin
				rt_vld[j] <= 1'b0;
			end
			for (int k = 0; k <= DIV_K; k++) begin
				dv_vld[k] <= 1'b0;
			end
		end else begin
			valid_s1  <= in_valid;
			rt_vld[0] <= valid_s1;
			for (int j = 0; j < RT_N; j++) begin
				rt_vld[j+1] <= rt_vld[j];
			end
			dv_vld[0] <= rt_vld[RT_N];
			for (int k = 0; k < DIV_K; k++) begin
				dv_vld[k+1] <= dv_vld[k];
			end
			valid_q <= dv_vld[DIV_K];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mag_s1[i] <= mag_c[i];
			neg_s1[i] <= in_v[i][SC_W-1];
			sq_s1[i]  <= (2*MAG_W)'(mag_c[i]) * (2*MAG_W)'(mag_c[i]);
		end
		side_s1 <= in_side;

		rt_rad[0]  <= SQ_W'(sq_s1[0]) + SQ_W'(sq_s1[1]) + SQ_W'(sq_s1[2]);
		rt_rem[0]  <= '0;
		rt_q[0]    <= '0;
		rt_mag[0]  <= mag_s1;
		rt_neg[0]  <= neg_s1;
		rt_side[0] <= side_s1;
		for (int j = 0; j < RT_N; j++) begin
			rt_rad[j+1]  <= rt_rad[j] << 2;
			rt_rem[j+1]  <= rt_ge_c[j] ? rt_rem_c[j] - rt_try_c[j] : rt_rem_c[j];
			rt_q[j+1]    <= {rt_q[j][ROOT_W-2:0], rt_ge_c[j]};
			rt_mag[j+1]  <= rt_mag[j];
			rt_neg[j+1]  <= rt_neg[j];
			rt_side[j+1] <= rt_side[j];
		end

		dv_n[0]    <= rt_q[RT_N];
		dv_neg[0]  <= rt_neg[RT_N];
		dv_side[0] <= rt_side[RT_N];
		for (int i = 0; i < 3; i++) begin
			dv_r[0][i] <= ge0_c[i] ? a0_c[i] - rt_q[RT_N] : a0_c[i];
			dv_q[0][i] <= Q_W'(ge0_c[i]);
		end
		for (int k = 0; k < DIV_K; k++) begin
			dv_n[k+1]    <= dv_n[k];
			dv_neg[k+1]  <= dv_neg[k];
			dv_side[k+1] <= dv_side[k];
			for (int i = 0; i < 3; i++) begin
				dv_r[k+1][i] <= ROOT_W'(ge_c[k][i] ? r2_c[k][i] - {1'b0, dv_n[k]}
				                                   : r2_c[k][i]);
				dv_q[k+1][i] <= {dv_q[k][i][Q_W-2:0], ge_c[k][i]};
			end
		end

		for (int i = 0; i < 3; i++) begin
			e_q[i] <= dv_neg[DIV_K][i] ? -$signed(eu_c[i]) : $signed(eu_c[i]);
			o_q[i] <= dv_neg[DIV_K][i] ? -$signed(ou_c[i]) : $signed(ou_c[i]);
		end
		side_q <= dv_side[DIV_K];
	end

	assign out_valid = valid_q;
	assign out_e     = e_q;
	assign out_o     = o_q;
	assign out_side  = side_q;

endmodule

FILE: src/gram_schmidt_orthonormalize_3x3_top.sv
// Top level of the 3x3 modified Gram-Schmidt orthonormalizer.
// Depends on gso_pkg, gso_scale, gso_proj and gso_unit.
//
// A request is taken on every cycle that start is high: busy is tied low and the
// block is a free-running pipeline, one matrix in and one result out per cycle.
// Each result appears on u0_*..u2_* and degenerate for exactly one cycle with done
// high, in request order; the receiver cannot stall, so it must take every result.
// The pipeline holds three normalizers in series, with K = max(FRAC_BITS, 30) + 1,
// each K + 36 stages (a squaring stage, a 33-stage square root, K+1 long-division
// stages and a rounding stage), plus two 5-stage projection units, three 3-stage
// block scalers in series and the output register.
// degenerate is high when a vector, or a residual after its projections, is exactly
// zero; that vector and every later one then read zero.
module gram_schmidt_orthonormalize_3x3_top #(
	parameter int DATA_WIDTH = gso_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = gso_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [DATA_WIDTH-1:0] v0_x,
	input  logic signed [DATA_WIDTH-1:0] v0_y,
	input  logic signed [DATA_WIDTH-1:0] v0_z,
	input  logic signed [DATA_WIDTH-1:0] v1_x,
	input  logic signed [DATA_WIDTH-1:0] v1_y,
	input  logic signed [DATA_WIDTH-1:0] v1_z,
	input  logic signed [DATA_WIDTH-1:0] v2_x,
	input  logic signed [DATA_WIDTH-1:0] v2_y,
	input  logic signed [DATA_WIDTH-1:0] v2_z,
	output logic                         done,
	output logic signed [FRAC_BITS+1:0]  u0_x,
	output logic signed [FRAC_BITS+1:0]  u0_y,
	output logic signed [FRAC_BITS+1:0]  u0_z,
	output logic signed [FRAC_BITS+1:0]  u1_x,
	output logic signed [FRAC_BITS+1:0]  u1_y,
	output logic signed [FRAC_BITS+1:0]  u1_z,
	output logic signed [FRAC_BITS+1:0]  u2_x,
	output logic signed [FRAC_BITS+1:0]  u2_y,
	output logic signed [FRAC_BITS+1:0]  u2_z,
	output logic                         degenerate
);
	import gso_pkg::*;

	localparam int OUT_W  = FRAC_BITS + 2;
	localparam int SIDE_B = 6*SC_W + 1;
	localparam int SIDE_C = 1 + 3*OUT_W;
	localparam int SIDE_D = 3*SC_W + 2 + SIDE_C;
	localparam int SIDE_E = 3*OUT_W + 2 + SIDE_C;
	localparam int SIDE_F = SIDE_E + 1;

	// stage A: block-scale all three input vectors side by side
	logic signed [DATA_WIDTH-1:0] va0 [3], va1 [3], va2 [3];
	logic signed [SC_W-1:0] v0s [3], v1s [3], v2s [3];
	logic valid_a, z0;

	// stage B: normalize v0
	logic [SIDE_B-1:0] side_b_in, side_b_out;
	logic signed [SC_W-1:0] v1b [3], v2b [3];
	logic z0b, valid_b;
	logic signed [E_W-1:0]   e0 [3];
	logic signed [OUT_W-1:0] o0 [3];

	// stage C: drop the v0 projection from v1 and v2, rescale
	logic [SIDE_C-1:0] side_c_in, side_pc, side_sc;
	logic signed [RES_W-1:0] r1 [3], r2 [3];
	logic valid_pc, valid_c;
	logic signed [SC_W-1:0] v1c [3], v2c [3];
	logic z1c, z2a_c;

	// stage D: normalize v1
	logic [SIDE_D-1:0] side_d_in, side_d_out;
	logic signed [SC_W-1:0] v2d [3];
	logic z2a_d, z1_d, valid_d;
	logic [SIDE_C-1:0] side_cd;
	logic signed [E_W-1:0]   e1 [3];
	logic signed [OUT_W-1:0] o1 [3];

	// stage E: drop the u1 projection from v2, rescale, normalize
	logic [SIDE_E-1:0] side_e_in, side_pe, side_se;
	logic signed [RES_W-1:0] r3 [3];
	logic valid_pe, valid_se, z2b_e;
	logic signed [SC_W-1:0] v2e [3];
	logic [SIDE_F-1:0] side_f_in, side_f_out;
	logic valid_f;
	logic signed [OUT_W-1:0] o2 [3];
	logic z0_f, z1_f, z2a_f, z2b_f;
	logic signed [OUT_W-1:0] o0_f [3], o1_f [3];
	logic keep0, keep1, keep2;

	// result register
	logic done_q, degenerate_q;
	logic signed [OUT_W-1:0] res_q [9];

	// every cycle can take a request
	assign busy = 1'b0;

	assign va0[0] = v0_x;
	assign va0[1] = v0_y;
	assign va0[2] = v0_z;
	assign va1[0] = v1_x;
	assign va1[1] = v1_y;
	assign va1[2] = v1_z;
	assign va2[0] = v2_x;
	assign va2[1] = v2_y;
	assign va2[2] = v2_z;

	gso_scale #(.IW(DATA_WIDTH), .SIDE_W(1)) u_scale_a0 (
		.clk(clk), .arst_n(arst_n), .in_valid(start), .in_v(va0), .in_side(1'b0),
		.out_valid(valid_a), .out_v(v0s), .out_zero(z0), .out_side()
	);
	gso_scale #(.IW(DATA_WIDTH), .SIDE_W(1)) u_scale_a1 (
		.clk(clk), .arst_n(arst_n), .in_valid(start), .in_v(va1), .in_side(1'b0),
		.out_valid(), .out_v(v1s), .out_zero(), .out_side()
	);
	gso_scale #(.IW(DATA_WIDTH), .SIDE_W(1)) u_scale_a2 (
		.clk(clk), .arst_n(arst_n), .in_valid(start), .in_v(va2), .in_side(1'b0),
		.out_valid(), .out_v(v2s), .out_zero(), .out_side()
	);

	// carry the scaled v1 and v2 along while v0 is normalized
	assign side_b_in = {v1s[0], v1s[1], v1s[2], v2s[0], v2s[1], v2s[2], z0};

	gso_unit #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE_B)) u_unit_b (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_a), .in_v(v0s), .in_side(side_b_in),
		.out_valid(valid_b), .out_e(e0), .out_o(o0), .out_side(side_b_out)
	);

	assign {v1b[0], v1b[1], v1b[2], v2b[0], v2b[1], v2b[2], z0b} = side_b_out;
	assign side_c_in = {z0b, o0[0], o0[1], o0[2]};

	gso_proj #(.SIDE_W(SIDE_C)) u_proj_c1 (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_b), .in_x(v1b), .in_e(e0),
		.in_side(side_c_in), .out_valid(valid_pc), .out_r(r1), .out_side(side_pc)
	);
	gso_proj #(.SIDE_W(1)) u_proj_c2 (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_b), .in_x(v2b), .in_e(e0),
		.in_side(1'b0), .out_valid(), .out_r(r2), .out_side()
	);

	gso_scale #(.IW(RES_W), .SIDE_W(SIDE_C)) u_scale_c1 (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_pc), .in_v(r1), .in_side(side_pc),
		.out_valid(valid_c), .out_v(v1c), .out_zero(z1c), .out_side(side_sc)
	);
	gso_scale #(.IW(RES_W), .SIDE_W(1)) u_scale_c2 (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_pc), .in_v(r2), .in_side(1'b0),
		.out_valid(), .out_v(v2c), .out_zero(z2a_c), .out_side()
	);

	assign side_d_in = {v2c[0], v2c[1], v2c[2], z2a_c, z1c, side_sc};

	gso_unit #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE_D)) u_unit_d (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_c), .in_v(v1c), .in_side(side_d_in),
		.out_valid(valid_d), .out_e(e1), .out_o(o1), .out_side(side_d_out)
	);

	assign {v2d[0], v2d[1], v2d[2], z2a_d, z1_d, side_cd} = side_d_out;
	assign side_e_in = {o1[0], o1[1], o1[2], z2a_d, z1_d, side_cd};

	gso_proj #(.SIDE_W(SIDE_E)) u_proj_e (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_d), .in_x(v2d), .in_e(e1),
		.in_side(side_e_in), .out_valid(valid_pe), .out_r(r3), .out_side(side_pe)
	);

	gso_scale #(.IW(RES_W), .SIDE_W(SIDE_E)) u_scale_e (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_pe), .in_v(r3), .in_side(side_pe),
		.out_valid(valid_se), .out_v(v2e), .out_zero(z2b_e), .out_side(side_se)
	);

	assign side_f_in = {z2b_e, side_se};

	gso_unit #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE_F)) u_unit_f (
		.clk(clk), .arst_n(arst_n), .in_valid(valid_se), .in_v(v2e), .in_side(side_f_in),
		.out_valid(valid_f), .out_e(), .out_o(o2), .out_side(side_f_out)
	);

	assign {z2b_f, o1_f[0], o1_f[1], o1_f[2], z2a_f, z1_f,
	        z0_f, o0_f[0], o0_f[1], o0_f[2]} = side_f_out;

	// a zero vector drops itself and every vector after it
	assign keep0 = !z0_f;
	assign keep1 = keep0 && !z1_f;
	assign keep2 = keep1 && !z2a_f && !z2b_f;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_f;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			res_q[i]   <= keep0 ? o0_f[i] : '0;
			res_q[3+i] <= keep1 ? o1_f[i] : '0;
			res_q[6+i] <= keep2 ? o2[i]   : '0;
		end
		degenerate_q <= !keep2;
	end

	assign done       = done_q;
	assign u0_x       = res_q[0];
	assign u0_y       = res_q[1];
	assign u0_z       = res_q[2];
	assign u1_x       = res_q[3];
	assign u1_y       = res_q[4];
	assign u1_z       = res_q[5];
	assign u2_x       = res_q[6];
	assign u2_y       = res_q[7];
	assign u2_z       = res_q[8];
	assign degenerate = degenerate_q;

endmodule
